>>> design/bktf_pkg.sv
// bktf_pkg: shared types, codes and fixed-point helpers for the box tracker
// no dependencies; imported by every module of the tracker
`timescale 1ns / 1ps
`default_nettype none

package bktf_pkg;

    // request codes carried on req_type
    typedef enum logic [1:0] {
        REQ_INIT    = 2'd0,
        REQ_PREDICT = 2'd1,
        REQ_UPDATE  = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    // datapath operations issued by the controller
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_RATIO_GO,
        OP_RATIO_SAVE,
        OP_INIT,
        OP_PREDICT,
        OP_GAIN_GO,
        OP_MUL,
        OP_SCALE,
        OP_WRITE,
        OP_HIT,
        OP_RESULT
    } t_op;

    // product terms of one correction step, plus the box width
    typedef enum logic [2:0] {
        TERM_KP_Y  = 3'd0,
        TERM_KV_Y  = 3'd1,
        TERM_KP_PP = 3'd2,
        TERM_KP_PV = 3'd3,
        TERM_KV_PV = 3'd4,
        TERM_WIDTH = 3'd5
    } t_term;

    localparam int TERM_COUNT = 6;
    localparam int AXES       = 4;
    localparam int FRAC_BITS  = 16;
    localparam int DIV_STEPS  = 48;

    typedef struct packed {
        t_op        op;
        logic [1:0] axis;
        t_term      sel;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_dp_status;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -64'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // arithmetic shift right rounding toward zero
    function automatic logic signed [63:0] shr_trunc(input logic signed [63:0] v,
                                                     input int sh);
        logic signed [64:0] a;
        logic signed [64:0] bias;
        bias = (65'sd1 <<< sh) - 65'sd1;
        a = {v[63], v} + (v[63] ? bias : 65'sd0);
        a = a >>> sh;
        return a[63:0];
    endfunction

    // q16.16 product rescale: (a*b)/65536 toward zero, saturated
    function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
        return sat32(shr_trunc(p, FRAC_BITS));
    endfunction

endpackage

`default_nettype wire

>>> design/bktf_div.sv
// bktf_div: two-lane restoring divider, (num << 16) / den toward zero, saturated
// depends on bktf_pkg; shared by the ratio and gain computations
`timescale 1ns / 1ps
`default_nettype none

module bktf_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num0,
    input  wire logic signed [31:0] i_num1,
    input  wire logic signed [33:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quo0,
    output logic signed [31:0]      o_quo1
);
    import bktf_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [33:0] r_rem0, r_rem1;
    logic [47:0] r_d0, r_d1;
    logic [33:0] r_v;
    logic        r_neg0, r_neg1, r_zero;

    logic [31:0] mag0, mag1;
    logic [33:0] vmag;
    logic [34:0] t0, t1;
    logic        q0, q1;
    logic signed [63:0] s0, s1;

    always_comb begin
        mag0 = i_num0[31] ? 32'(-i_num0) : 32'(i_num0);
        mag1 = i_num1[31] ? 32'(-i_num1) : 32'(i_num1);
        vmag = i_den[33] ? 34'(-i_den) : 34'(i_den);
        t0 = {r_rem0, r_d0[47]};
        t1 = {r_rem1, r_d1[47]};
        q0 = (t0 >= {1'b0, r_v});
        q1 = (t1 >= {1'b0, r_v});
        s0 = r_neg0 ? -$signed({16'd0, r_d0}) : $signed({16'd0, r_d0});
        s1 = r_neg1 ? -$signed({16'd0, r_d1}) : $signed({16'd0, r_d1});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DIV_STEPS - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem0 <= '0;
            r_rem1 <= '0;
            r_d0   <= {mag0, 16'd0};
            r_d1   <= {mag1, 16'd0};
            r_v    <= vmag;
            r_neg0 <= i_num0[31] ^ i_den[33];
            r_neg1 <= i_num1[31] ^ i_den[33];
            r_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_rem0 <= q0 ? 34'(t0 - {1'b0, r_v}) : t0[33:0];
            r_rem1 <= q1 ? 34'(t1 - {1'b0, r_v}) : t1[33:0];
            r_d0   <= {r_d0[46:0], q0};
            r_d1   <= {r_d1[46:0], q1};
        end
    end

    assign o_done = r_done;
    assign o_quo0 = r_zero ? 32'sd0 : sat32(s0);
    assign o_quo1 = r_zero ? 32'sd0 : sat32(s1);

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy) else $error("divider restarted while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("divider done while still busy");
    a_fall_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_busy) |-> r_done) else $error("divider stopped without done");

endmodule

`default_nettype wire

>>> design/bktf_datapath.sv
// bktf_datapath: track state, request latch, shared multiplier and divider, result register
// depends on bktf_pkg and bktf_div; driven by bktf_ctrl commands
`timescale 1ns / 1ps
`default_nettype none

module bktf_datapath (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_load,
    input  wire logic [15:0]         i_box_x,
    input  wire logic [15:0]         i_box_y,
    input  wire logic [14:0]         i_box_width,
    input  wire logic [14:0]         i_box_height,
    input  wire logic [31:0]         i_q_position,
    input  wire logic [31:0]         i_q_velocity_xy,
    input  wire logic [31:0]         i_q_velocity_shape,
    input  wire logic [31:0]         i_r_measure,
    input  wire logic [31:0]         i_p_initial,
    input  wire bktf_pkg::t_dp_cmd   i_cmd,
    output bktf_pkg::t_dp_status     o_status,
    input  wire logic                i_ready,
    output logic                     o_valid,
    output logic signed [15:0]       o_est_x,
    output logic signed [15:0]       o_est_y,
    output logic signed [15:0]       o_est_width,
    output logic signed [15:0]       o_est_height,
    output logic [15:0]              o_hit_count,
    output logic [15:0]              o_frames_missed
);
    import bktf_pkg::*;

    logic signed [31:0] r_pos [AXES];
    logic signed [31:0] r_vel [AXES];
    logic signed [31:0] r_pp  [AXES];
    logic signed [31:0] r_pv  [AXES];
    logic signed [31:0] r_vv  [AXES];
    logic [15:0]        r_hits, r_missed;

    logic [15:0] r_bx, r_by;
    logic [14:0] r_bw, r_bh;
    logic signed [31:0] r_z2;
    logic signed [31:0] r_y;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_term [TERM_COUNT];

    logic               r_ovalid;
    logic signed [15:0] r_ex, r_ey, r_ew, r_eh;
    logic [15:0]        r_ohit, r_omiss;

    logic               div_start, div_done;
    logic signed [31:0] div_n0, div_n1, kp, kv;
    logic signed [33:0] div_den;
    logic signed [31:0] z [AXES];
    logic signed [31:0] pp_a, pv_a, pos_a;
    logic signed [31:0] ma, mb;
    logic signed [31:0] pinit;
    logic               out_free;
    logic signed [63:0] ex_num, ey_num;

    bktf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num0  (div_n0),
        .i_num1  (div_n1),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo0  (kp),
        .o_quo1  (kv)
    );

    // measurement terms: centre = edge*65536 + size*32768, height in q16.16
    always_comb begin
        z[0] = sat32($signed({{32{r_bx[15]}}, r_bx, 16'd0}) + $signed({34'd0, r_bw, 15'd0}));
        z[1] = sat32($signed({{32{r_by[15]}}, r_by, 16'd0}) + $signed({34'd0, r_bh, 15'd0}));
        z[2] = r_z2;
        z[3] = $signed({1'b0, r_bh, 16'd0});
    end

    always_comb begin
        pp_a  = r_pp[i_cmd.axis];
        pv_a  = r_pv[i_cmd.axis];
        pos_a = r_pos[i_cmd.axis];
        div_start = (i_cmd.op == OP_RATIO_GO) || (i_cmd.op == OP_GAIN_GO);
        if (i_cmd.op == OP_RATIO_GO) begin
            div_n0  = $signed({17'd0, r_bw});
            div_n1  = 32'sd0;
            div_den = $signed({19'd0, r_bh});
        end else begin
            div_n0  = pp_a;
            div_n1  = pv_a;
            div_den = $signed({{2{pp_a[31]}}, pp_a}) + $signed({2'b0, i_r_measure});
        end
        case (i_cmd.sel)
            TERM_KP_Y:  begin ma = kp; mb = r_y;  end
            TERM_KV_Y:  begin ma = kv; mb = r_y;  end
            TERM_KP_PP: begin ma = kp; mb = pp_a; end
            TERM_KP_PV: begin ma = kp; mb = pv_a; end
            TERM_KV_PV: begin ma = kv; mb = pv_a; end
            TERM_WIDTH: begin ma = r_pos[2]; mb = r_pos[3]; end
            default:    begin ma = 32'sd0; mb = 32'sd0; end
        endcase
        pinit    = i_p_initial[31] ? 32'sh7FFF_FFFF : $signed(i_p_initial);
        out_free = !r_ovalid || i_ready;
        ex_num = ($signed({{31{r_pos[0][31]}}, r_pos[0], 1'b0})
                 - $signed({{32{r_term[TERM_WIDTH][31]}}, r_term[TERM_WIDTH]}));
        ey_num = ($signed({{31{r_pos[1][31]}}, r_pos[1], 1'b0})
                 - $signed({{32{r_pos[3][31]}}, r_pos[3]}));
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bx <= i_box_x;
            r_by <= i_box_y;
            r_bw <= i_box_width;
            r_bh <= i_box_height;
        end
        if (i_cmd.op == OP_RATIO_SAVE) begin
            r_z2 <= kp;
        end
        if (i_cmd.op == OP_GAIN_GO) begin
            r_y <= sat32($signed({{32{z[i_cmd.axis][31]}}, z[i_cmd.axis]})
                         - $signed({{32{pos_a[31]}}, pos_a}));
        end
        if (i_cmd.op == OP_MUL) begin
            r_prod <= 64'(ma * mb);
        end
        if (i_cmd.op == OP_SCALE) begin
            r_term[i_cmd.sel] <= qscale(r_prod);
        end
        if (i_cmd.op == OP_RESULT && out_free) begin
            r_ex    <= sat16(shr_trunc(ex_num, FRAC_BITS + 1));
            r_ey    <= sat16(shr_trunc(ey_num, FRAC_BITS + 1));
            r_ew    <= sat16(shr_trunc(64'(r_term[TERM_WIDTH]), FRAC_BITS));
            r_eh    <= sat16(shr_trunc(64'(r_pos[3]), FRAC_BITS));
            r_ohit  <= r_hits;
            r_omiss <= r_missed;
        end
    end

    // track state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_pos[i] <= '0;
                r_vel[i] <= '0;
                r_pp[i]  <= '0;
                r_pv[i]  <= '0;
                r_vv[i]  <= '0;
            end
            r_hits   <= '0;
            r_missed <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (i_cmd.op)
                OP_INIT: begin
                    for (int i = 0; i < AXES; i++) begin
                        r_pos[i] <= z[i];
                        r_vel[i] <= '0;
                        r_pp[i]  <= pinit;
                        r_pv[i]  <= '0;
                        r_vv[i]  <= pinit;
                    end
                    r_hits   <= 16'd1;
                    r_missed <= '0;
                end
                OP_PREDICT: begin
                    for (int i = 0; i < AXES; i++) begin
                        r_pos[i] <= sat32(64'(r_pos[i]) + 64'(r_vel[i]));
                        r_pp[i]  <= sat32(64'(r_pp[i]) + 2 * 64'(r_pv[i]) + 64'(r_vv[i])
                                          + $signed({32'd0, i_q_position}));
                        r_pv[i]  <= sat32(64'(r_pv[i]) + 64'(r_vv[i]));
                        r_vv[i]  <= sat32(64'(r_vv[i]) + $signed({32'd0,
                                    (i < 2) ? i_q_velocity_xy : i_q_velocity_shape}));
                    end
                    if (r_missed != 16'hFFFF) begin
                        r_missed <= r_missed + 16'd1;
                    end
                end
                OP_WRITE: begin
                    r_pos[i_cmd.axis] <= sat32(64'(pos_a) + 64'(r_term[TERM_KP_Y]));
                    r_vel[i_cmd.axis] <= sat32(64'(r_vel[i_cmd.axis])
                                               + 64'(r_term[TERM_KV_Y]));
                    r_pp[i_cmd.axis]  <= sat32(64'(pp_a) - 64'(r_term[TERM_KP_PP]));
                    r_pv[i_cmd.axis]  <= sat32(64'(pv_a) - 64'(r_term[TERM_KP_PV]));
                    r_vv[i_cmd.axis]  <= sat32(64'(r_vv[i_cmd.axis])
                                               - 64'(r_term[TERM_KV_PV]));
                end
                OP_HIT: begin
                    if (r_hits != 16'hFFFF) begin
                        r_hits <= r_hits + 16'd1;
                    end
                    r_missed <= '0;
                end
                default: begin
                end
            endcase
            if (i_cmd.op == OP_RESULT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_status.div_done = div_done;
    assign o_status.out_free = out_free;
    assign o_valid         = r_ovalid;
    assign o_est_x         = r_ex;
    assign o_est_y         = r_ey;
    assign o_est_width     = r_ew;
    assign o_est_height    = r_eh;
    assign o_hit_count     = r_ohit;
    assign o_frames_missed = r_omiss;

endmodule

`default_nettype wire

>>> design/bktf_ctrl.sv
// bktf_ctrl: sequencer that walks one request through the datapath
// depends on bktf_pkg; commands bktf_datapath
`timescale 1ns / 1ps
`default_nettype none

module bktf_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic [1:0]           i_req_type,
    input  wire bktf_pkg::t_dp_status i_status,
    output bktf_pkg::t_dp_cmd         o_cmd,
    output logic                      o_ready
);
    import bktf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RATIO_GO, S_RATIO_WAIT, S_RATIO_SAVE, S_INIT, S_PREDICT,
        S_GAIN_GO, S_GAIN_WAIT, S_MUL, S_SCALE, S_WRITE, S_HIT,
        S_WMUL, S_WSCALE, S_RESULT
    } t_state;

    t_state     r_state;
    t_req       r_req;
    logic [1:0] r_axis;
    t_term      r_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= REQ_NONE;
            r_axis  <= '0;
            r_sel   <= TERM_KP_Y;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        r_req <= t_req'(i_req_type);
                        case (t_req'(i_req_type))
                            REQ_INIT, REQ_UPDATE: r_state <= S_RATIO_GO;
                            REQ_PREDICT:          r_state <= S_PREDICT;
                            default:              r_state <= S_WMUL;
                        endcase
                    end
                end
                S_RATIO_GO: r_state <= S_RATIO_WAIT;
                S_RATIO_WAIT: begin
                    if (i_status.div_done) begin
                        r_state <= S_RATIO_SAVE;
                    end
                end
                S_RATIO_SAVE: begin
                    r_axis  <= '0;
                    r_state <= (r_req == REQ_INIT) ? S_INIT : S_GAIN_GO;
                end
                S_INIT:    r_state <= S_WMUL;
                S_PREDICT: r_state <= S_WMUL;
                S_GAIN_GO: r_state <= S_GAIN_WAIT;
                S_GAIN_WAIT: begin
                    if (i_status.div_done) begin
                        r_sel   <= TERM_KP_Y;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_SCALE;
                S_SCALE: begin
                    if (r_sel == TERM_KV_PV) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_sel   <= t_term'(r_sel + 3'd1);
                        r_state <= S_MUL;
                    end
                end
                S_WRITE: begin
                    if (r_axis == 2'(AXES - 1)) begin
                        r_state <= S_HIT;
                    end else begin
                        r_axis  <= r_axis + 2'd1;
                        r_state <= S_GAIN_GO;
                    end
                end
                S_HIT:    r_state <= S_WMUL;
                S_WMUL:   r_state <= S_WSCALE;
                S_WSCALE: r_state <= S_RESULT;
                S_RESULT: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.axis = r_axis;
        o_cmd.sel  = r_sel;
        case (r_state)
            S_RATIO_GO:   o_cmd.op = OP_RATIO_GO;
            S_RATIO_SAVE: o_cmd.op = OP_RATIO_SAVE;
            S_INIT:       o_cmd.op = OP_INIT;
            S_PREDICT:    o_cmd.op = OP_PREDICT;
            S_GAIN_GO:    o_cmd.op = OP_GAIN_GO;
            S_MUL:        o_cmd.op = OP_MUL;
            S_SCALE:      o_cmd.op = OP_SCALE;
            S_WRITE:      o_cmd.op = OP_WRITE;
            S_HIT:        o_cmd.op = OP_HIT;
            S_WMUL: begin
                o_cmd.op  = OP_MUL;
                o_cmd.sel = TERM_WIDTH;
            end
            S_WSCALE: begin
                o_cmd.op  = OP_SCALE;
                o_cmd.sel = TERM_WIDTH;
            end
            S_RESULT:     o_cmd.op = OP_RESULT;
            default:      o_cmd.op = OP_IDLE;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

>>> design/box_track_kalman_filter_unit.sv
// box_track_kalman_filter_unit: top level of the single-box kalman tracker
// depends on bktf_pkg, bktf_ctrl, bktf_datapath (which holds bktf_div)
//
// usage
//   input channel (i_valid / o_ready) carries one request: req_type selects
//   init from box, predict one frame or update with box; code 3 only reports
//   output channel (o_valid / i_ready) returns one result per request: the
//   estimated box (left, top, width, height) and the hit and miss counters
//   apb port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds the five
//   noise and covariance registers at byte offsets 0, 4, 8, 12, 16
// one request at a time, from accept to result valid
//   predict and report only skip the divider; init and update run the 48-step
//   two-lane divider once for the box ratio, and update then runs it once per
//   axis for both gains
//   o_ready rises with the result, and the next request can be taken from then on
// reset (synchronous, active low) clears the track state and counters and
//   loads the register defaults
// receiver stall: the result sits in the output register; a following
//   request still runs and waits at its end until that register frees up
`timescale 1ns / 1ps
`default_nettype none

module box_track_kalman_filter_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // request channel
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [1:0]         i_req_type,
    input  wire logic [15:0]        i_box_x,
    input  wire logic [15:0]        i_box_y,
    input  wire logic [14:0]        i_box_width,
    input  wire logic [14:0]        i_box_height,
    // result channel
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [15:0]      o_est_x,
    output logic signed [15:0]      o_est_y,
    output logic signed [15:0]      o_est_width,
    output logic signed [15:0]      o_est_height,
    output logic [15:0]             o_hit_count,
    output logic [15:0]             o_frames_missed,
    // configuration
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import bktf_pkg::*;

    // register indexes (byte offset / 4)
    localparam logic [2:0] REG_Q_POSITION       = 3'd0;
    localparam logic [2:0] REG_Q_VELOCITY_XY    = 3'd1;
    localparam logic [2:0] REG_Q_VELOCITY_SHAPE = 3'd2;
    localparam logic [2:0] REG_R_MEASURE        = 3'd3;
    localparam logic [2:0] REG_P_INITIAL        = 3'd4;

    logic [31:0] r_q_position, r_q_velocity_xy, r_q_velocity_shape;
    logic [31:0] r_r_measure, r_p_initial;

    logic       accept;
    logic       cfg_write;
    logic [2:0] reg_index;
    t_dp_cmd    cmd;
    t_dp_status status;

    assign accept    = i_valid && o_ready;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[4:2];
    assign pready    = 1'b1;

    // configuration registers, written on the apb access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_position       <= 32'd655;
            r_q_velocity_xy    <= 32'd6554;
            r_q_velocity_shape <= 32'd655;
            r_r_measure        <= 32'd6554;
            r_p_initial        <= 32'd65536;
        end else if (cfg_write) begin
            case (reg_index)
                REG_Q_POSITION:       r_q_position       <= pwdata;
                REG_Q_VELOCITY_XY:    r_q_velocity_xy    <= pwdata;
                REG_Q_VELOCITY_SHAPE: r_q_velocity_shape <= pwdata;
                REG_R_MEASURE:        r_r_measure        <= pwdata;
                REG_P_INITIAL:        r_p_initial        <= pwdata;
                default: begin
                end
            endcase
        end
    end

    // read back, unused offsets read as zero
    always_comb begin
        case (reg_index)
            REG_Q_POSITION:       prdata = r_q_position;
            REG_Q_VELOCITY_XY:    prdata = r_q_velocity_xy;
            REG_Q_VELOCITY_SHAPE: prdata = r_q_velocity_shape;
            REG_R_MEASURE:        prdata = r_r_measure;
            REG_P_INITIAL:        prdata = r_p_initial;
            default:              prdata = '0;
        endcase
    end

    // sequencer: one request walks ratio, gains, products and writeback
    bktf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_req_type (i_req_type),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_ready    (o_ready)
    );

    // state, arithmetic units and the output register
    bktf_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (accept),
        .i_box_x            (i_box_x),
        .i_box_y            (i_box_y),
        .i_box_width        (i_box_width),
        .i_box_height       (i_box_height),
        .i_q_position       (r_q_position),
        .i_q_velocity_xy    (r_q_velocity_xy),
        .i_q_velocity_shape (r_q_velocity_shape),
        .i_r_measure        (r_r_measure),
        .i_p_initial        (r_p_initial),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_ready            (i_ready),
        .o_valid            (o_valid),
        .o_est_x            (o_est_x),
        .o_est_y            (o_est_y),
        .o_est_width        (o_est_width),
        .o_est_height       (o_est_height),
        .o_hit_count        (o_hit_count),
        .o_frames_missed    (o_frames_missed)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_ready) else $error("request taken while previous one runs");
    a_result_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_RESULT && status.out_free) |=> o_valid)
        else $error("finished result not presented");
    a_ready_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (cmd.op == OP_IDLE)) else $error("datapath busy while idle");

endmodule

`default_nettype wire
